// File: rtl/dpmq_pkg.sv
// Package for the dual PIR motion qualifier: field widths, action codes,
// timing constants, the per-level tables and the controller/datapath structs.
// No dependencies.
`default_nettype none

package dpmq_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned ActionW = 2;
  localparam int unsigned PinW    = 2;

  localparam logic [TimeW-1:0] GlitchMs = TimeW'(20);
  localparam logic [TimeW-1:0] QuietMs  = TimeW'(300);
  localparam logic [LevelW-1:0] LevelReset = LevelW'(2);

  typedef enum logic [ActionW-1:0] {
    ACT_EDGE  = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } dpmq_action_t;

  // Encoding shared by the open pulse and the trigger direction.
  localparam logic [PinW-1:0] PIN_NONE = 2'd0;

  // Sensitivity timeout per level.
  function automatic logic [TimeW-1:0] timeout_ms(input logic [LevelW-1:0] lvl);
    logic [TimeW-1:0] t;
    unique case (lvl)
      2'd0:    t = TimeW'(0);
      2'd1:    t = TimeW'(10000);
      2'd2:    t = TimeW'(5000);
      default: t = TimeW'(2000);
    endcase
    return t;
  endfunction

  // Accepted-pulse limit per level.
  function automatic logic [CountW-1:0] event_limit(input logic [LevelW-1:0] lvl);
    logic [CountW-1:0] n;
    unique case (lvl)
      2'd0:    n = CountW'(32);
      2'd1:    n = CountW'(10);
      2'd2:    n = CountW'(5);
      default: n = CountW'(2);
    endcase
    return n;
  endfunction

  typedef struct packed {
    logic latch;      // capture the accepted item
    logic calc;       // register the time differences
    logic apply;      // update the movement record
    logic div_start;  // start the mean division
    logic load_out;   // move the result into the output register
  } dpmq_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dpmq_sts_t;

endpackage

`default_nettype wire

// File: rtl/dpmq_ifs.sv
// Valid/ready channel interfaces for the motion qualifier's item and result.
// Depends on dpmq_pkg for field widths.
`default_nettype none

interface dpmq_in_if;
  logic                          valid;
  logic                          ready;
  logic [dpmq_pkg::ActionW-1:0]  action;
  logic                          edge_pin;
  logic                          edge_falling;
  logic [dpmq_pkg::TimeW-1:0]    time_ms;
  logic                          level_h;
  logic                          level_l;

  modport source (output valid, action, edge_pin, edge_falling, time_ms, level_h, level_l,
                  input ready);
  modport sink   (input valid, action, edge_pin, edge_falling, time_ms, level_h, level_l,
                  output ready);
endinterface

interface dpmq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pulse_accepted;
  logic                          glitch_dropped;
  logic                          movement_end;
  logic                          limit_reached;
  logic [dpmq_pkg::PinW-1:0]     direction;
  logic [dpmq_pkg::CountW-1:0]   pulse_count;
  logic [dpmq_pkg::TimeW-1:0]    mean_duration;

  modport source (output valid, pulse_accepted, glitch_dropped, movement_end, limit_reached,
                  direction, pulse_count, mean_duration, input ready);
  modport sink   (input valid, pulse_accepted, glitch_dropped, movement_end, limit_reached,
                  direction, pulse_count, mean_duration, output ready);
endinterface

`default_nettype wire

// File: rtl/dual_pir_motion_qualifier.sv
// Dual PIR motion qualifier, top level. An accepted item is captured, its time
// differences registered and the movement record updated, then a 32-step serial
// divide of the duration sum by the pulse count gives the mean for the result.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the movement record, the timers and
// the output valid flag, and sets the sensitivity level to mid.
`default_nettype none

module dual_pir_motion_qualifier (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dpmq_pkg::LevelW-1:0]   cfg_wdata,
  dpmq_in_if.sink                            in_ch,
  dpmq_out_if.source                         out_ch
);
  import dpmq_pkg::*;

  dpmq_cmd_t cmd;
  dpmq_sts_t sts;

  // The controller walks each item through capture, difference, update,
  // divide and output phases; it only accepts an item while idle.
  dpmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the open pulse, the movement record, the
  // sensitivity register, the mean divider and the output register.
  dpmq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_ch.action),
    .in_edge_pin        (in_ch.edge_pin),
    .in_edge_falling    (in_ch.edge_falling),
    .in_time_ms         (in_ch.time_ms),
    .in_level_h         (in_ch.level_h),
    .in_level_l         (in_ch.level_l),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_pulse_accepted (out_ch.pulse_accepted),
    .out_glitch_dropped (out_ch.glitch_dropped),
    .out_movement_end   (out_ch.movement_end),
    .out_limit_reached  (out_ch.limit_reached),
    .out_direction      (out_ch.direction),
    .out_pulse_count    (out_ch.pulse_count),
    .out_mean_duration  (out_ch.mean_duration)
  );

endmodule

`default_nettype wire

// File: rtl/dpmq_div.sv
// Restoring serial divider, one quotient bit per cycle, for the mean duration.
// Depends on dpmq_pkg for widths.
`default_nettype none

module dpmq_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dpmq_pkg::TimeW-1:0]    dividend,
  input  wire logic [dpmq_pkg::CountW-1:0]   divisor,
  output logic                               busy,
  output logic [dpmq_pkg::TimeW-1:0]         quotient
);
  import dpmq_pkg::*;

  localparam int unsigned CntW = $clog2(TimeW);

  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [TimeW-1:0]  quo_r, quo_nxt;
  logic [CountW-1:0] rem_r, rem_nxt;
  logic [CountW-1:0] dvs_r, dvs_nxt;
  logic [CountW:0]   rem_shift;
  logic [CountW:0]   rem_diff;

  assign rem_shift = {rem_r, quo_r[TimeW-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits in CountW bits.
      if (!rem_diff[CountW]) begin
        rem_nxt = rem_diff[CountW-1:0];
        quo_nxt = {quo_r[TimeW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[CountW-1:0];
        quo_nxt = {quo_r[TimeW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CntW'(1);
      if (cnt_r == CntW'(TimeW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/dpmq_ctrl.sv
// Sequencing state machine of the motion qualifier: takes one item at a time
// and steps the datapath through its phases. Depends on dpmq_pkg.
`default_nettype none

module dpmq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dpmq_pkg::dpmq_sts_t  sts,
  output dpmq_pkg::dpmq_cmd_t       cmd
);
  import dpmq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_APPLY,
    ST_DSTART,
    ST_DWAIT,
    ST_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && ready_r) state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (!sts.div_busy) state_nxt = ST_PUSH;
      ST_PUSH:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == ST_IDLE);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.latch     = (state_r == ST_IDLE) && in_valid && ready_r;
    cmd.calc      = (state_r == ST_CALC);
    cmd.apply     = (state_r == ST_APPLY);
    cmd.div_start = (state_r == ST_DSTART);
    cmd.load_out  = (state_r == ST_PUSH) && sts.out_free;
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

// File: rtl/dpmq_dp.sv
// Datapath of the motion qualifier: item capture, movement record, mean
// divider and output register. Depends on dpmq_pkg, dpmq_div.
`default_nettype none

module dpmq_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dpmq_pkg::dpmq_cmd_t           cmd,
  output dpmq_pkg::dpmq_sts_t                sts,
  input  wire logic                          cfg_we,
  input  wire logic [dpmq_pkg::LevelW-1:0]   cfg_wdata,
  input  wire logic [dpmq_pkg::ActionW-1:0]  in_action,
  input  wire logic                          in_edge_pin,
  input  wire logic                          in_edge_falling,
  input  wire logic [dpmq_pkg::TimeW-1:0]    in_time_ms,
  input  wire logic                          in_level_h,
  input  wire logic                          in_level_l,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_pulse_accepted,
  output logic                               out_glitch_dropped,
  output logic                               out_movement_end,
  output logic                               out_limit_reached,
  output logic [dpmq_pkg::PinW-1:0]          out_direction,
  output logic [dpmq_pkg::CountW-1:0]        out_pulse_count,
  output logic [dpmq_pkg::TimeW-1:0]         out_mean_duration
);
  import dpmq_pkg::*;

  // Captured item.
  logic [ActionW-1:0] act_r;
  logic               pin_r, fall_r, lvl_h_r, lvl_l_r;
  logic [TimeW-1:0]   now_r;

  // Differences taken in the calc phase.
  logic [TimeW-1:0]   dur_r;
  logic               quiet_r, tmo_r;

  // Movement record.
  logic [LevelW-1:0]  level_r, level_nxt;
  logic [PinW-1:0]    open_pin_r, open_pin_nxt;
  logic [TimeW-1:0]   open_start_r, open_start_nxt;
  logic [TimeW-1:0]   timer_start_r, timer_start_nxt;
  logic               has_pulse_r, has_pulse_nxt;
  logic [TimeW-1:0]   last_edge_r, last_edge_nxt;
  logic [TimeW-1:0]   sum_r, sum_nxt;
  logic [CountW-1:0]  count_r, count_nxt;
  logic [PinW-1:0]    dir_r, dir_nxt;
  logic               acc_f_r, acc_f_nxt, gl_f_r, gl_f_nxt, end_f_r, end_f_nxt;

  // Output register.
  logic               ovalid_r, ovalid_nxt;
  logic               o_acc_r, o_gl_r, o_end_r, o_lim_r;
  logic [PinW-1:0]    o_dir_r;
  logic [CountW-1:0]  o_cnt_r;
  logic [TimeW-1:0]   o_mean_r;

  logic [TimeW:0]     sum_add;
  logic [PinW-1:0]    edge_code;
  logic               div_busy;
  logic [TimeW-1:0]   quotient;

  dpmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Pin H opens code 1, pin L code 2.
  assign edge_code = {pin_r, ~pin_r};
  assign sum_add   = {1'b0, sum_r} + {1'b0, dur_r};

  always_comb begin
    level_nxt       = cfg_we ? cfg_wdata : level_r;
    open_pin_nxt    = open_pin_r;
    open_start_nxt  = open_start_r;
    timer_start_nxt = timer_start_r;
    has_pulse_nxt   = has_pulse_r;
    last_edge_nxt   = last_edge_r;
    sum_nxt         = sum_r;
    count_nxt       = count_r;
    dir_nxt         = dir_r;
    acc_f_nxt       = acc_f_r;
    gl_f_nxt        = gl_f_r;
    end_f_nxt       = end_f_r;
    if (cmd.apply) begin
      acc_f_nxt = 1'b0;
      gl_f_nxt  = 1'b0;
      end_f_nxt = 1'b0;
      unique case (dpmq_action_t'(act_r))
        ACT_EDGE: begin
          if (fall_r) begin
            if (open_pin_r == PIN_NONE) begin
              open_pin_nxt    = edge_code;
              open_start_nxt  = now_r;
              timer_start_nxt = now_r;
            end
          end else if (open_pin_r == edge_code) begin
            if (dur_r >= GlitchMs) begin
              // The closing edge time is the pulse start plus its length.
              has_pulse_nxt = 1'b1;
              last_edge_nxt = now_r;
              if (count_r == '0) begin
                dir_nxt = open_pin_r;
              end
              if (count_r != '1) begin
                count_nxt = count_r + CountW'(1);
              end
              sum_nxt   = sum_add[TimeW] ? '1 : sum_add[TimeW-1:0];
              acc_f_nxt = 1'b1;
            end else begin
              gl_f_nxt = 1'b1;
            end
            open_pin_nxt = PIN_NONE;
          end
        end
        ACT_POLL: begin
          end_f_nxt = has_pulse_r && lvl_h_r && lvl_l_r && (quiet_r || tmo_r);
        end
        ACT_CLEAR: begin
          open_pin_nxt  = PIN_NONE;
          has_pulse_nxt = 1'b0;
          sum_nxt       = '0;
          count_nxt     = '0;
          dir_nxt       = PIN_NONE;
        end
        ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign ovalid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= LevelReset;
      open_pin_r    <= PIN_NONE;
      open_start_r  <= '0;
      timer_start_r <= '0;
      has_pulse_r   <= 1'b0;
      last_edge_r   <= '0;
      sum_r         <= '0;
      count_r       <= '0;
      dir_r         <= PIN_NONE;
      acc_f_r       <= 1'b0;
      gl_f_r        <= 1'b0;
      end_f_r       <= 1'b0;
      ovalid_r      <= 1'b0;
    end else begin
      level_r       <= level_nxt;
      open_pin_r    <= open_pin_nxt;
      open_start_r  <= open_start_nxt;
      timer_start_r <= timer_start_nxt;
      has_pulse_r   <= has_pulse_nxt;
      last_edge_r   <= last_edge_nxt;
      sum_r         <= sum_nxt;
      count_r       <= count_nxt;
      dir_r         <= dir_nxt;
      acc_f_r       <= acc_f_nxt;
      gl_f_r        <= gl_f_nxt;
      end_f_r       <= end_f_nxt;
      ovalid_r      <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= in_action;
      pin_r   <= in_edge_pin;
      fall_r  <= in_edge_falling;
      now_r   <= in_time_ms;
      lvl_h_r <= in_level_h;
      lvl_l_r <= in_level_l;
    end
    if (cmd.calc) begin
      dur_r   <= now_r - open_start_r;
      quiet_r <= (now_r - last_edge_r) > QuietMs;
      tmo_r   <= (now_r - timer_start_r) >= timeout_ms(level_r);
    end
    if (cmd.load_out) begin
      o_acc_r  <= acc_f_r;
      o_gl_r   <= gl_f_r;
      o_end_r  <= end_f_r;
      o_lim_r  <= count_r >= event_limit(level_r);
      o_dir_r  <= dir_r;
      o_cnt_r  <= count_r;
      o_mean_r <= (count_r == '0) ? '0 : quotient;
    end
  end

  always_comb begin
    sts          = '0;
    sts.div_busy = div_busy;
    sts.out_free = !ovalid_r || out_ready;
  end

  assign out_valid          = ovalid_r;
  assign out_pulse_accepted = o_acc_r;
  assign out_glitch_dropped = o_gl_r;
  assign out_movement_end   = o_end_r;
  assign out_limit_reached  = o_lim_r;
  assign out_direction      = o_dir_r;
  assign out_pulse_count    = o_cnt_r;
  assign out_mean_duration  = o_mean_r;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the dual PIR motion qualifier: directed edge cases,
// sweeps of every sensitivity level and random well-formed movements with noise.
// Depends on dpmq_pkg, dpmq_in_if/dpmq_out_if and dual_pir_motion_qualifier.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpmq_pkg::*;

  // Element and edge encodings of the item fields, and the sensitivity levels.
  localparam logic EL_H    = 1'b0;
  localparam logic EL_L    = 1'b1;
  localparam logic FALLING = 1'b1;
  localparam logic RISING  = 1'b0;

  localparam logic [PinW-1:0] PIN_H = 2'd1;
  localparam logic [PinW-1:0] PIN_L = 2'd2;

  localparam logic [LevelW-1:0] LVL_NONE = 2'd0;
  localparam logic [LevelW-1:0] LVL_LOW  = 2'd1;
  localparam logic [LevelW-1:0] LVL_MID  = 2'd2;
  localparam logic [LevelW-1:0] LVL_HIGH = 2'd3;

  // Drain margin kept before the register is touched or the run is closed.
  localparam int unsigned DRAIN_CYCLES = 45;
  localparam int unsigned RANDOM_ITEMS = 896;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned MAX_PRINTED  = 100;

  typedef struct packed {
    dpmq_action_t     action;
    logic             pin;
    logic             falling;
    logic [TimeW-1:0] stamp;
    logic             lvl_h;
    logic             lvl_l;
  } pir_item_t;

  typedef struct packed {
    logic              accepted;
    logic              glitch;
    logic              ended;
    logic              at_limit;
    logic [PinW-1:0]   direction;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  mean;
  } pir_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [LevelW-1:0] cfg_wdata;

  dpmq_in_if  in_ch ();
  dpmq_out_if out_ch ();

  dual_pir_motion_qualifier uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted copy of the block's movement record and sensitivity register.
  logic [PinW-1:0]   mov_open_pin;
  logic [TimeW-1:0]  mov_open_start;
  logic [TimeW-1:0]  mov_last_start;
  logic [TimeW-1:0]  mov_last_len;
  logic [TimeW-1:0]  mov_len_sum;
  logic [CountW-1:0] mov_pulses;
  logic [PinW-1:0]   mov_direction;
  logic [TimeW-1:0]  mov_timer_start;
  logic [LevelW-1:0] mov_level;

  // Reports owed by the block, oldest first.
  pir_report_t expected_reports[$];

  // Timestamp that the random generator walks forward.
  logic [TimeW-1:0] gen_now;
  // When set, neither side idles: items and results move back to back.
  bit steady_flow;

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned reports_checked;
  int unsigned pulses_seen;
  int unsigned glitches_seen;
  int unsigned ends_seen;
  int unsigned limits_seen;
  int unsigned cycle_count;

  function automatic logic [TimeW-1:0] level_timeout(input logic [LevelW-1:0] lvl);
    case (lvl)
      LVL_NONE: return TimeW'(0);
      LVL_LOW:  return TimeW'(10000);
      LVL_MID:  return TimeW'(5000);
      default:  return TimeW'(2000);
    endcase
  endfunction

  function automatic logic [CountW-1:0] level_limit(input logic [LevelW-1:0] lvl);
    case (lvl)
      LVL_NONE: return CountW'(32);
      LVL_LOW:  return CountW'(10);
      LVL_MID:  return CountW'(5);
      default:  return CountW'(2);
    endcase
  endfunction

  function automatic pir_item_t make_item(input dpmq_action_t act, input logic pin,
                                          input logic falling, input logic [TimeW-1:0] stamp,
                                          input logic h = 1'b1, input logic l = 1'b1);
    pir_item_t it;
    it.action  = act;
    it.pin     = pin;
    it.falling = falling;
    it.stamp   = stamp;
    it.lvl_h   = h;
    it.lvl_l   = l;
    return it;
  endfunction

  // A clear drops the open pulse and everything accepted so far, but the
  // sensitivity timer and the register survive it.
  task automatic clear_movement();
    mov_open_pin   = PIN_NONE;
    mov_open_start = '0;
    mov_last_start = '0;
    mov_last_len   = '0;
    mov_len_sum    = '0;
    mov_pulses     = '0;
    mov_direction  = PIN_NONE;
  endtask

  // Applies one accepted item to the predicted record and works out its report.
  task automatic qualify_motion(input pir_item_t it, output pir_report_t rep);
    logic [PinW-1:0]  pin_code;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] last_edge;
    logic [TimeW-1:0] timer_age;
    rep = '0;
    pin_code = (it.pin == EL_L) ? PIN_L : PIN_H;
    case (it.action)
      ACT_EDGE: begin
        if (it.falling == FALLING) begin
          // Only a falling edge with nothing open starts a pulse; it also
          // restarts the sensitivity timer.
          if (mov_open_pin == PIN_NONE) begin
            mov_open_pin    = pin_code;
            mov_open_start  = it.stamp;
            mov_timer_start = it.stamp;
          end
        end else if (mov_open_pin != PIN_NONE && mov_open_pin == pin_code) begin
          // Durations are taken modulo 2^32, so a wrapped clock still works.
          span = it.stamp - mov_open_start;
          if (span >= GlitchMs) begin
            mov_last_start = mov_open_start;
            mov_last_len   = span;
            if (mov_pulses == '0) mov_direction = mov_open_pin;
            if (mov_pulses != '1) mov_pulses = mov_pulses + CountW'(1);
            mov_len_sum = (mov_len_sum > ~span) ? '1 : mov_len_sum + span;
            rep.accepted = 1'b1;
          end else begin
            rep.glitch = 1'b1;
          end
          mov_open_pin   = PIN_NONE;
          mov_open_start = '0;
        end
      end
      ACT_POLL: begin
        if (mov_last_len != '0 && it.lvl_h && it.lvl_l) begin
          last_edge = mov_last_start + mov_last_len;
          span      = it.stamp - last_edge;
          timer_age = it.stamp - mov_timer_start;
          if (span > QuietMs || timer_age >= level_timeout(mov_level)) rep.ended = 1'b1;
        end
      end
      ACT_CLEAR: clear_movement();
      default: ;
    endcase
    rep.at_limit  = (mov_pulses >= level_limit(mov_level));
    rep.direction = mov_direction;
    rep.count     = mov_pulses;
    rep.mean      = (mov_pulses != '0) ? mov_len_sum / mov_pulses : '0;
  endtask

  // Presents one item after a random pause and waits for the block to take
  // it. The valid line is only dropped when a pause is drawn, so back-to-back
  // items keep it high without a second assignment in the same step.
  task automatic send_item(input pir_item_t it);
    int unsigned gap;
    pir_report_t rep;
    gap = steady_flow ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.edge_pin     <= it.pin;
    in_ch.edge_falling <= it.falling;
    in_ch.time_ms      <= it.stamp;
    in_ch.level_h      <= it.lvl_h;
    in_ch.level_l      <= it.lvl_l;
    do @(posedge clk); while (!in_ch.ready);
    qualify_motion(it, rep);
    expected_reports.push_back(rep);
    items_sent++;
  endtask

  // Stops the item stream and lets every owed report come out, plus the
  // block's latency so nothing is still in flight.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register is only written with the block idle.
  task automatic set_sensitivity(input logic [LevelW-1:0] lvl);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mov_level = lvl;
  endtask

  // Draws the next random item. Most items follow the open/close discipline
  // of a real sensor, using the predicted record to know what is open; the
  // rest are stray edges, polls, clears, the unused action and pure noise.
  task automatic random_motion_item(output pir_item_t it);
    int unsigned pick;
    logic [TimeW-1:0] len;
    it = make_item(dpmq_action_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    pick = $urandom_range(0, 99);
    // Now and then the clock jumps close to its wrap point.
    if ($urandom_range(0, 199) == 0) gen_now = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    if (pick < 6) begin
      // Pure noise: every field as drawn above.
    end else if (mov_open_pin != PIN_NONE && pick < 75) begin
      case ($urandom_range(0, 19))
        0, 1, 2: len = $urandom_range(0, 19);
        3:       len = $urandom_range(19, 20);
        4:       len = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(20, 40);
        default: len = $urandom_range(20, 2500);
      endcase
      gen_now    = mov_open_start + len;
      it.action  = ACT_EDGE;
      it.falling = RISING;
      it.pin     = (mov_open_pin == PIN_L) ? EL_L : EL_H;
      it.stamp   = gen_now;
    end else if (mov_open_pin != PIN_NONE && pick < 87) begin
      // A second falling edge, or a rising edge on the element that is not open.
      gen_now    = gen_now + $urandom_range(0, 10);
      it.action  = ACT_EDGE;
      it.falling = 1'($urandom_range(0, 1));
      if (it.falling == RISING) it.pin = (mov_open_pin == PIN_L) ? EL_H : EL_L;
      it.stamp   = gen_now;
    end else if (mov_open_pin == PIN_NONE && pick < 55) begin
      gen_now    = gen_now + $urandom_range(1, 3000);
      it.action  = ACT_EDGE;
      it.falling = FALLING;
      it.stamp   = gen_now;
    end else if (pick < 92) begin
      it.action = ACT_POLL;
      it.lvl_h  = ($urandom_range(0, 5) != 0);
      it.lvl_l  = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 3))
        0: it.stamp = mov_last_start + mov_last_len + $urandom_range(298, 302);
        1: it.stamp = mov_timer_start + level_timeout(mov_level) + $urandom_range(0, 2) - 1;
        2: it.stamp = mov_timer_start + $urandom_range(0, 12000);
        default: it.stamp = gen_now + $urandom_range(0, 400);
      endcase
    end else if (pick < 95) begin
      it.action = ACT_CLEAR;
    end else if (pick < 97) begin
      it.action = ACT_NONE;
    end else begin
      // Rising edge with nothing open, or on a pin that may not match.
      it.action  = ACT_EDGE;
      it.falling = RISING;
      it.stamp   = gen_now;
    end
  endtask

  // Opening and closing of pulses, glitches, ignored edges, the quiet time of
  // a poll on both sides of its bound, polls with a pin low, the unused action
  // and a clear, all at the reset level (mid).
  task automatic test_pulse_qualification();
    send_item(make_item(ACT_POLL, EL_H, RISING, 32'd0));           // nothing accepted yet
    send_item(make_item(ACT_EDGE, EL_H, RISING, 32'd5));           // nothing open
    send_item(make_item(ACT_EDGE, EL_H, FALLING, 32'd100));        // opens H
    send_item(make_item(ACT_EDGE, EL_L, FALLING, 32'd110));        // already open
    send_item(make_item(ACT_EDGE, EL_L, RISING, 32'd115));         // other element
    send_item(make_item(ACT_EDGE, EL_H, RISING, 32'd120));         // exactly 20 ms
    send_item(make_item(ACT_EDGE, EL_L, FALLING, 32'd200));
    send_item(make_item(ACT_EDGE, EL_L, RISING, 32'd219));         // 19 ms glitch
    send_item(make_item(ACT_POLL, EL_L, FALLING, 32'd420));        // quiet exactly 300 ms
    send_item(make_item(ACT_POLL, EL_H, RISING, 32'd421, 1'b1, 1'b0));
    send_item(make_item(ACT_POLL, EL_H, RISING, 32'd421, 1'b0, 1'b1));
    send_item(make_item(ACT_POLL, EL_H, RISING, 32'd421));          // quiet 301 ms
    send_item(make_item(ACT_NONE, EL_L, FALLING, 32'hFFFF_FFFF));
    send_item(make_item(ACT_CLEAR, EL_L, FALLING, 32'hFFFF_FFFF, 1'b0, 1'b0));
  endtask

  // Pulses across the timestamp wrap, a duration sum that saturates, a poll
  // that ends on the sensitivity timeout alone, and a clear afterwards.
  task automatic test_wrap_and_saturation();
    send_item(make_item(ACT_EDGE, EL_L, FALLING, 32'hFFFF_FFF0));
    send_item(make_item(ACT_EDGE, EL_L, RISING, 32'h0000_0010));
    send_item(make_item(ACT_EDGE, EL_H, FALLING, 32'h0000_0020));
    send_item(make_item(ACT_EDGE, EL_H, RISING, 32'hF000_0020));
    send_item(make_item(ACT_EDGE, EL_H, FALLING, 32'hF000_0100));
    send_item(make_item(ACT_EDGE, EL_H, RISING, 32'hE000_0100));
    send_item(make_item(ACT_POLL, EL_H, RISING, 32'hE000_0164));
    send_item(make_item(ACT_CLEAR, EL_H, RISING, 32'h0000_0000, 1'b0, 1'b0));
  endtask

  // Every level in turn, extremes first: one movement of two pulses with a poll
  // after the first, then polls one millisecond before and exactly at the level's
  // timeout, inside the quiet time at every level but none.
  task automatic test_sensitivity_levels();
    logic [LevelW-1:0] order [4];
    logic [TimeW-1:0]  base;
    logic [TimeW-1:0]  tmo;
    logic [TimeW-1:0]  len;
    order = '{LVL_NONE, LVL_HIGH, LVL_LOW, LVL_MID};
    foreach (order[i]) begin
      set_sensitivity(order[i]);
      base = TimeW'(50_000) * (i + 1);
      tmo  = level_timeout(order[i]);
      len  = (tmo >= 120) ? tmo - 100 : TimeW'(50);
      send_item(make_item(ACT_CLEAR, EL_H, RISING, base));
      send_item(make_item(ACT_EDGE, EL_H, FALLING, base));
      send_item(make_item(ACT_EDGE, EL_H, RISING, base + 50));
      send_item(make_item(ACT_POLL, EL_H, RISING, base + 60));
      send_item(make_item(ACT_EDGE, EL_L, FALLING, base + 100));
      send_item(make_item(ACT_EDGE, EL_L, RISING, base + 100 + len));
      send_item(make_item(ACT_POLL, EL_L, RISING, base + 100 + tmo - 1));
      send_item(make_item(ACT_POLL, EL_L, RISING, base + 100 + tmo));
    end
  endtask

  // Random movements in phases: the level changes between phases, extremes
  // first, and stretches without any idling on either side come and go.
  task automatic test_random_movements();
    logic [LevelW-1:0] lvl;
    pir_item_t it;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 160 == 0) begin
        case (n / 160)
          0:       lvl = LVL_NONE;
          1:       lvl = LVL_HIGH;
          2:       lvl = LVL_LOW;
          3:       lvl = LVL_MID;
          default: lvl = LevelW'($urandom_range(0, 3));
        endcase
        set_sensitivity(lvl);
      end
      if (n % 48 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      random_motion_item(it);
      send_item(it);
    end
    steady_flow = 1'b0;
  endtask

  task automatic flag_mismatch(input string field, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
    error_count++;
    if (error_count <= MAX_PRINTED) $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // Result side: takes results after random stalls; a stall of zero keeps
  // ready high so results can leave back to back.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Every result taken is compared with the oldest report still owed.
  always @(posedge clk) begin
    pir_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= MAX_PRINTED) $error("result arrived with no item outstanding");
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        pulses_seen   += want.accepted;
        glitches_seen += want.glitch;
        ends_seen     += want.ended;
        limits_seen   += want.at_limit;
        if (out_ch.pulse_accepted !== want.accepted)
          flag_mismatch("pulse_accepted", TimeW'(want.accepted),
                        TimeW'(out_ch.pulse_accepted));
        if (out_ch.glitch_dropped !== want.glitch)
          flag_mismatch("glitch_dropped", TimeW'(want.glitch),
                        TimeW'(out_ch.glitch_dropped));
        if (out_ch.movement_end !== want.ended)
          flag_mismatch("movement_end", TimeW'(want.ended), TimeW'(out_ch.movement_end));
        if (out_ch.limit_reached !== want.at_limit)
          flag_mismatch("limit_reached", TimeW'(want.at_limit),
                        TimeW'(out_ch.limit_reached));
        if (out_ch.direction !== want.direction)
          flag_mismatch("direction", TimeW'(want.direction), TimeW'(out_ch.direction));
        if (out_ch.pulse_count !== want.count)
          flag_mismatch("pulse_count", TimeW'(want.count), TimeW'(out_ch.pulse_count));
        if (out_ch.mean_duration !== want.mean)
          flag_mismatch("mean_duration", want.mean, out_ch.mean_duration);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d reports still owed",
             cycle_count, expected_reports.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    // All inputs are known from time zero, while reset is held asserted.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_NONE;
    in_ch.edge_pin     = 1'b0;
    in_ch.edge_falling = 1'b0;
    in_ch.time_ms      = '0;
    in_ch.level_h      = 1'b0;
    in_ch.level_l      = 1'b0;
    steady_flow        = 1'b0;
    gen_now            = '0;
    error_count        = 0;
    items_sent         = 0;
    reports_checked    = 0;
    pulses_seen        = 0;
    glitches_seen      = 0;
    ends_seen          = 0;
    limits_seen        = 0;
    // Prediction starts from the reset state: empty record, mid level.
    clear_movement();
    mov_timer_start = '0;
    mov_level       = LevelReset;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_pulse_qualification();
    test_wrap_and_saturation();
    test_sensitivity_levels();
    test_random_movements();

    wait_until_drained();
    $display("Sent %0d items over all four sensitivity levels; %0d results checked.",
             items_sent, reports_checked);
    $display("Expected %0d accepted pulses, %0d glitches, %0d movement ends, %0d at limit.",
             pulses_seen, glitches_seen, ends_seen, limits_seen);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
